### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: shared types and codes of the sorted priority queue
// used by the channel interfaces, the slot cell and the top level

package spq_pkg;

  typedef logic signed [31:0] spq_value_t;
  typedef logic signed [15:0] spq_prio_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } spq_status_t;

  // broadcast from the top level to every slot cell
  typedef struct packed {
    logic       ins;
    logic       rm;
    spq_value_t value;
    spq_prio_t  prio;
  } spq_ctl_t;

endpackage

### rtl/spq_in_if.sv
`timescale 1ns / 1ps
// spq_in_if: request channel of the sorted priority queue
// depends on spq_pkg

interface spq_in_if
  import spq_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       cmd;
  spq_value_t item_value;
  spq_prio_t  item_priority;

  modport source (output valid, cmd, item_value, item_priority, input ready);
  modport sink (input valid, cmd, item_value, item_priority, output ready);
endinterface

### rtl/spq_out_if.sv
`timescale 1ns / 1ps
// spq_out_if: result channel of the sorted priority queue
// depends on spq_pkg

interface spq_out_if
  import spq_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  spq_value_t             removed_value;
  spq_prio_t              removed_priority;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, removed_value, removed_priority, status, entry_count,
                  input ready);
  modport sink (input valid, removed_value, removed_priority, status, entry_count,
                output ready);
endinterface

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted shift-register queue
// depends on spq_pkg; instantiated in a row by sorted_priority_queue

module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  spq_ctl_t   ctl_i,
  input  logic       occupied_i,
  input  logic       prev_stay_i,
  input  spq_value_t prev_value_i,
  input  spq_prio_t  prev_prio_i,
  input  spq_value_t next_value_i,
  input  spq_prio_t  next_prio_i,
  output logic       stay_o,
  output spq_value_t value_o,
  output spq_prio_t  prio_o
);

  spq_value_t value_r, value_nxt;
  spq_prio_t  prio_r, prio_nxt;

  // entry stays put on insert when it is at or below the new priority
  assign stay_o  = occupied_i && (prio_r <= ctl_i.prio);
  assign value_o = value_r;
  assign prio_o  = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctl_i.ins && !stay_o) begin
      if (prev_stay_i) begin
        value_nxt = ctl_i.value;
        prio_nxt  = ctl_i.prio;
      end else begin
        value_nxt = prev_value_i;
        prio_nxt  = prev_prio_i;
      end
    end else if (ctl_i.rm) begin
      value_nxt = next_value_i;
      prio_nxt  = next_prio_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule

### rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted_priority_queue: bounded priority queue, smallest priority at the head
// usage:
//   in_ch carries a request: cmd (insert or remove), item_value, item_priority.
//   out_ch returns one result per request: the removed value and priority
//   (zero unless a remove succeeded), a status (done, underflow, overflow)
//   and the entry count after the request.
//   entries live in a row of QUEUE_DEPTH slot cells; on every request all
//   cells compare their priority with the new one in parallel and each cell
//   keeps, loads the new entry or takes its neighbor's entry.
//   equal priorities leave in arrival order.
//   the result is registered and valid in the cycle after acceptance.
//   throughput: one request per cycle while the receiver keeps ready high.
//   a request is accepted while the result register is empty or being taken,
//   so a stalled receiver holds the result and stalls the input behind it.
//   reset empties the queue and the result register; slot contents are left
//   as they are and are only read below the entry count.
// depends on spq_pkg, spq_in_if, spq_out_if and spq_cell

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  spq_value_t       out_value_r;
  spq_prio_t        out_prio_r;
  spq_status_t      out_status_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  logic             accept;
  logic             full;
  logic             empty;
  spq_ctl_t         ctl;
  spq_status_t      status_nxt;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  logic       stay [QUEUE_DEPTH];
  spq_value_t cell_value [QUEUE_DEPTH];
  spq_prio_t  cell_prio [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    ctl.value  = in_ch.item_value;
    ctl.prio   = in_ch.item_priority;
    ctl.ins    = accept && (in_ch.cmd == CMD_INSERT) && !full;
    ctl.rm     = accept && (in_ch.cmd == CMD_REMOVE) && !empty;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (in_ch.cmd == CMD_INSERT) begin
      if (full) status_nxt = ST_OVERFLOW;
      else      count_nxt  = count_r + 1'b1;
    end else begin
      if (empty) status_nxt = ST_UNDERFLOW;
      else       count_nxt  = count_r - 1'b1;
    end
    count_ext = {{COUNT_OUT_W{1'b0}}, count_nxt};
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic       prev_stay;
    spq_value_t prev_value, next_value;
    spq_prio_t  prev_prio, next_prio;

    if (i == 0) begin : g_head
      assign prev_stay  = 1'b1;
      assign prev_value = cell_value[i];
      assign prev_prio  = cell_prio[i];
    end else begin : g_body
      assign prev_stay  = stay[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_prio  = cell_prio[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .occupied_i   (count_r > CNT_W'(i)),
      .prev_stay_i  (prev_stay),
      .prev_value_i (prev_value),
      .prev_prio_i  (prev_prio),
      .next_value_i (next_value),
      .next_prio_i  (next_prio),
      .stay_o       (stay[i]),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r  <= ctl.rm ? cell_value[0] : '0;
      out_prio_r   <= ctl.rm ? cell_prio[0] : '0;
      out_status_r <= status_nxt;
      out_count_r  <= count_ext[COUNT_OUT_W-1:0];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.removed_value    = out_value_r;
  assign out_ch.removed_priority = out_prio_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.entry_count      = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_OVERFLOW) |-> full)
    else $error("overflow reported while queue not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_UNDERFLOW) |-> empty)
    else $error("underflow reported while queue not empty");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rm |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not lower entry count");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench of sorted_priority_queue, insert and remove requests
// checked one to one against a slot-array predictor, with random stalls on both sides
// depends on spq_pkg, spq_in_if, spq_out_if and sorted_priority_queue

module testbench;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 1930;

  typedef struct {
    logic       cmd;
    spq_value_t value;
    spq_prio_t  prio;
  } queue_req_t;

  typedef struct {
    spq_value_t             value;
    spq_prio_t              prio;
    spq_status_t            status;
    logic [COUNT_OUT_W-1:0] count;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  queue_req_t    pending_reqs[$];
  queue_result_t results_due[$];

  // predictor state
  spq_value_t slot_val[DEPTH];
  spq_prio_t  slot_pri[DEPTH];
  int         slot_count;

  int error_count;
  int results_seen;
  int n_inserts, n_removes, n_underflows, n_overflows, peak_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_queue_op(queue_req_t r);
    queue_result_t res;
    int pos;
    res.value  = '0;
    res.prio   = '0;
    res.status = ST_DONE;
    if (r.cmd == CMD_INSERT) begin
      n_inserts++;
      if (slot_count >= DEPTH) begin
        res.status = ST_OVERFLOW;
        n_overflows++;
      end else begin
        pos = 0;
        while (pos < slot_count && slot_pri[pos] <= r.prio) pos++;
        for (int i = slot_count; i > pos; i--) begin
          slot_val[i] = slot_val[i-1];
          slot_pri[i] = slot_pri[i-1];
        end
        slot_val[pos] = r.value;
        slot_pri[pos] = r.prio;
        slot_count++;
      end
    end else begin
      n_removes++;
      if (slot_count == 0) begin
        res.status = ST_UNDERFLOW;
        n_underflows++;
      end else begin
        res.value = slot_val[0];
        res.prio  = slot_pri[0];
        for (int i = 1; i < slot_count; i++) begin
          slot_val[i-1] = slot_val[i];
          slot_pri[i-1] = slot_pri[i];
        end
        slot_count--;
      end
    end
    if (slot_count > peak_count) peak_count = slot_count;
    res.count = COUNT_OUT_W'(slot_count);
    results_due.push_back(res);
  endfunction

  // driver
  queue_req_t cur_req;
  int         send_gap;
  int         send_fast_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
      send_fast_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_queue_op(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.cmd           <= cur_req.cmd;
          in_ch.item_value    <= cur_req.value;
          in_ch.item_priority <= cur_req.prio;
          in_ch.valid         <= 1'b1;
          if (send_fast_left > 0) begin
            send_gap = 0;
            send_fast_left--;
          end else if ($urandom_range(0, 19) == 0) begin
            send_gap = 0;
            send_fast_left = $urandom_range(20, 80);
          end else begin
            send_gap = $urandom_range(0, 18);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  queue_result_t want;
  int            recv_stall;
  int            recv_fast_left;
  bit            long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
      recv_fast_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.removed_value !== want.value) begin
            $error("removed_value: expected %0d, got %0d", want.value, out_ch.removed_value);
            error_count++;
          end
          if (out_ch.removed_priority !== want.prio) begin
            $error("removed_priority: expected %0d, got %0d", want.prio,
                   out_ch.removed_priority);
            error_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            error_count++;
          end
          if (out_ch.entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_ch.entry_count);
            error_count++;
          end
        end
        // long hold-off so the input backs up behind the held result
        if (!long_hold_done && results_seen > 200 && pending_reqs.size() > 100) begin
          recv_stall = 300;
          long_hold_done = 1'b1;
        end else if (recv_fast_left > 0) begin
          recv_stall = 0;
          recv_fast_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          recv_stall = 0;
          recv_fast_left = $urandom_range(20, 80);
        end else begin
          recv_stall = $urandom_range(0, 18);
        end
      end
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  task automatic push_req(logic cmd, spq_value_t value, spq_prio_t prio);
    queue_req_t r;
    r.cmd   = cmd;
    r.value = value;
    r.prio  = prio;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic spq_prio_t pick_prio(int mode);
    spq_prio_t p;
    case (mode)
      0: p = spq_prio_t'($urandom);
      1: p = spq_prio_t'($urandom_range(0, 8) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0: p = 16'sh8000;
          1: p = 16'sh8001;
          2: p = 16'sh7ffe;
          3: p = 16'sh7fff;
          default: p = '0;
        endcase
      end
    endcase
    return p;
  endfunction

  initial begin
    int left, seg, insert_pct, prio_mode, batch_size;
    spq_value_t v;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_INSERT;
    in_ch.item_value    = '0;
    in_ch.item_priority = '0;
    out_ch.ready        = 1'b0;
    rst_n               = 1'b0;
    slot_count = 0;
    error_count = 0;
    results_seen = 0;
    n_inserts = 0;
    n_removes = 0;
    n_underflows = 0;
    n_overflows = 0;
    peak_count = 0;
    long_hold_done = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // remove on empty, fill with extremes and ties, overflow, then drain a few
    push_req(CMD_REMOVE, 32'sh7fffffff, 16'sh7fff);
    push_req(CMD_INSERT, 32'sh7fffffff, 16'sh7fff);
    push_req(CMD_INSERT, 32'sh80000000, 16'sh8000);
    push_req(CMD_INSERT, 32'sd0, 16'sd0);
    push_req(CMD_INSERT, -32'sd1, 16'sd0);
    push_req(CMD_INSERT, 32'sd1, 16'sd0);
    push_req(CMD_INSERT, 32'sh55555555, -16'sd1);
    push_req(CMD_INSERT, 32'shaaaaaaaa, 16'sd1);
    push_req(CMD_INSERT, 32'sd7, 16'sh7fff);
    push_req(CMD_INSERT, 32'sd8, 16'sh8000);
    for (int i = 0; i < 7; i++) push_req(CMD_INSERT, 32'sd100 + i, 16'sd5);
    push_req(CMD_INSERT, 32'sh12345678, 16'sh8000);
    for (int i = 0; i < 3; i++) push_req(CMD_REMOVE, '0, '0);
    wait_drained();

    // random batches; the sender waits for every result between batches
    left = RANDOM_REQS;
    while (left > 0) begin
      batch_size = (left < 330) ? left : 330;
      left -= batch_size;
      while (batch_size > 0) begin
        seg = $urandom_range(20, 60);
        if (seg > batch_size) seg = batch_size;
        batch_size -= seg;
        case ($urandom_range(0, 3))
          0: insert_pct = 20;
          1: insert_pct = 50;
          2: insert_pct = 55;
          default: insert_pct = 85;
        endcase
        prio_mode = $urandom_range(0, 2);
        for (int i = 0; i < seg; i++) begin
          v = spq_value_t'($urandom);
          if ($urandom_range(0, 99) < insert_pct)
            push_req(CMD_INSERT, v, pick_prio(prio_mode));
          else
            push_req(CMD_REMOVE, v, spq_prio_t'($urandom));
        end
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    $display("covered %0d inserts (%0d overflow) and %0d removes (%0d underflow)",
             n_inserts, n_overflows, n_removes, n_underflows);
    $display("peak occupancy %0d of %0d, %0d results checked", peak_count, DEPTH,
             results_seen);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/testbench.sv
